@@ rtl/core/ffca_pkg.sv @@
// shared types and constants for the first-fit cell allocator
// no dependencies; used by the allocator and the word scan in rtl/core

package ffca_pkg;

  // default number of cells in the occupancy map
  localparam int CELLS_DEF = 1024;

  // field widths
  localparam int CELL_W = 11;  // cell counts and cell indexes
  localparam int BASE_W = 10;  // base field of a transfer
  localparam int KIND_W = 1;

  // the map is held as words of LANES cells
  localparam int LANE_W  = 5;
  localparam int LANES   = 1 << LANE_W;
  localparam int WIDX_W  = CELL_W - LANE_W;
  localparam int RUN_W   = CELL_W + 1;

  localparam logic [CELL_W-1:0] TOTAL_RST = CELL_W'(1024);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MPRE,
    ST_MARK,
    ST_DONE
  } ffca_state_t;

  // outcome of scanning one map word
  typedef struct packed {
    logic              hit;
    logic [CELL_W-1:0] end_cell;  // cell at which the run reaches the size
    logic [CELL_W-1:0] run;       // free run carried into the next word
  } scan_res_t;

endpackage

@@ rtl/core/first_fit_cell_allocator.sv @@
// first-fit cell allocator: occupancy map in ram, scan and mark sequencer
// allocate: accept, scan up to ceil(total/32) map words, prepare, mark the run's words, then
// load the result register (with no fit the scan goes straight to the result); free skips the scan;
// rejected requests go straight to the result. one transfer at a time, set by the single map read
// port walking one 32-cell word per cycle.
// reset and each total_cells write clear the map, one word per cycle

module first_fit_cell_allocator #(
  parameter int CELLS = ffca_pkg::CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,     // total_cells
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [10:0] size, [20:11] base, zero padding
  input  logic        in_tuser,      // kind
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [9:0] granted_base, [20:10] used_cells,
                                     // [31:21] free_cells
  output logic        out_tuser      // ok
);
  import ffca_pkg::*;

  localparam int WORDS = (CELLS + LANES - 1) / LANES;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [CELL_W-1:0] CELLS_CAP = CELL_W'((CELLS > 2047) ? 2047 : CELLS);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(WORDS - 1);

  function automatic logic [CELL_W-1:0] eff_of(input logic [CELL_W-1:0] t);
    eff_of = (t > CELLS_CAP) ? CELLS_CAP : t;
  endfunction

  // state
  ffca_state_t       state_r, state_nxt;
  logic [CELL_W-1:0] total_cells_r, total_cells_nxt;
  logic [CELL_W-1:0] used_r, used_nxt;
  logic [CELL_W-1:0] free_r, free_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // request in flight
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [CELL_W-1:0] size_r, size_nxt;
  logic [CELL_W-1:0] base_r, base_nxt;   // first cell of the run
  logic [CELL_W-1:0] last_r, last_nxt;   // last cell of the run
  logic [WIDX_W-1:0] word_r, word_nxt;   // word whose read data arrives now
  logic [CELL_W-1:0] run_r, run_nxt;
  logic              ok_r, ok_nxt;

  // result register
  logic              out_ok_r, out_ok_nxt;
  logic [BASE_W-1:0] out_base_r, out_base_nxt;
  logic [CELL_W-1:0] out_used_r, out_used_nxt;
  logic [CELL_W-1:0] out_free_r, out_free_nxt;

  // incoming fields
  logic [KIND_W-1:0] in_kind;
  logic [CELL_W-1:0] in_size;
  logic [BASE_W-1:0] in_base;
  logic              in_xfer;
  logic              out_xfer;
  logic              req_ok;
  logic [CELL_W:0]   free_end;

  logic [CELL_W-1:0] eff_total;
  logic [WIDX_W-1:0] last_word;
  logic [WIDX_W-1:0] mark_end;
  logic              load_out;

  // map ram
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [LANES-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [LANES-1:0]  ram_rdata;
  logic [LANES-1:0]  mark_mask;

  scan_res_t         scan;

  assign in_kind  = in_tuser;
  assign in_size  = in_tdata[10:0];
  assign in_base  = in_tdata[20:11];
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_valid_r && out_tready;

  assign eff_total = eff_of(total_cells_r);
  assign last_word = WIDX_W'(CELL_W'(eff_total - CELL_W'(1)) >> LANE_W);
  assign mark_end  = last_r[CELL_W-1:LANE_W];
  assign free_end  = {1'b0, CELL_W'(in_base)} + {1'b0, in_size};

  // request check at acceptance
  always_comb begin
    if (in_kind == KIND_ALLOC) begin
      req_ok = (in_size != '0) && (in_size <= eff_total);
    end else begin
      req_ok = (in_size != '0) && (free_end <= {1'b0, eff_total});
    end
  end

  ffca_ram #(
    .WIDTH(LANES),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ffca_word_scan u_scan (
    .occ   (ram_rdata),
    .word  (word_r),
    .run_in(run_r),
    .size  (size_r),
    .total (eff_total),
    .res   (scan)
  );

  // cells of the current word that fall inside the run
  always_comb begin
    logic [CELL_W-1:0] cell_idx;
    for (int i = 0; i < LANES; i++) begin
      cell_idx = {word_r, LANE_W'(i)};
      mark_mask[i] = (cell_idx >= base_r) && (cell_idx <= last_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (!req_ok) begin
            state_nxt = ST_DONE;
          end else if (in_kind == KIND_ALLOC) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_MPRE;
          end
        end
      end
      ST_SCAN: begin
        if (scan.hit) begin
          state_nxt = ST_MPRE;
        end else if (word_r == last_word) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MPRE: state_nxt = ST_MARK;
      ST_MARK: begin
        if (word_r == mark_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    // a configuration write restarts the map
    if (cfg_we) begin
      state_nxt = ST_CLEAR;
    end
  end

  // outputs of the sequencer: ram port control and handshakes
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(word_r);
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_raddr = '0;
      end
      ST_SCAN: ram_raddr = AW'(WIDX_W'(word_r + WIDX_W'(1)));
      ST_MPRE: ram_raddr = AW'(base_r[CELL_W-1:LANE_W]);
      ST_MARK: begin
        ram_we    = 1'b1;
        ram_raddr = AW'(WIDX_W'(word_r + WIDX_W'(1)));
        if (kind_r == KIND_ALLOC) begin
          ram_wdata = ram_rdata | mark_mask;
        end else begin
          ram_wdata = ram_rdata & ~mark_mask;
        end
      end
      ST_DONE: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    logic [CELL_W:0] sum;
    total_cells_nxt = total_cells_r;
    used_nxt        = used_r;
    free_nxt        = free_r;
    clr_addr_nxt    = clr_addr_r;
    kind_nxt        = kind_r;
    size_nxt        = size_r;
    base_nxt        = base_r;
    last_nxt        = last_r;
    word_nxt        = word_r;
    run_nxt         = run_r;
    ok_nxt          = ok_r;
    out_ok_nxt      = out_ok_r;
    out_base_nxt    = out_base_r;
    out_used_nxt    = out_used_r;
    out_free_nxt    = out_free_r;
    out_valid_nxt   = out_valid_r && !out_xfer;
    sum             = '0;

    case (state_r)
      ST_CLEAR: clr_addr_nxt = AW'(clr_addr_r + AW'(1));
      ST_IDLE: begin
        if (in_xfer) begin
          kind_nxt = in_kind;
          size_nxt = in_size;
          base_nxt = CELL_W'(in_base);
          last_nxt = CELL_W'(free_end - (CELL_W + 1)'(1));
          word_nxt = '0;
          run_nxt  = '0;
          ok_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        word_nxt = WIDX_W'(word_r + WIDX_W'(1));
        run_nxt  = scan.run;
        if (scan.hit) begin
          base_nxt = CELL_W'(scan.end_cell - size_r + CELL_W'(1));
          last_nxt = scan.end_cell;
        end
      end
      ST_MPRE: word_nxt = base_r[CELL_W-1:LANE_W];
      ST_MARK: begin
        word_nxt = WIDX_W'(word_r + WIDX_W'(1));
        ok_nxt   = 1'b1;
      end
      ST_DONE: begin
        if (load_out) begin
          if (ok_r) begin
            if (kind_r == KIND_ALLOC) begin
              free_nxt = (free_r > size_r) ? CELL_W'(free_r - size_r) : '0;
              sum      = {1'b0, used_r} + {1'b0, size_r};
              used_nxt = (sum > {1'b0, eff_total}) ? eff_total : sum[CELL_W-1:0];
            end else begin
              used_nxt = (used_r > size_r) ? CELL_W'(used_r - size_r) : '0;
              sum      = {1'b0, free_r} + {1'b0, size_r};
              free_nxt = (sum > {1'b0, eff_total}) ? eff_total : sum[CELL_W-1:0];
            end
          end
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_base_nxt  = (ok_r && kind_r == KIND_ALLOC) ? base_r[BASE_W-1:0] : '0;
          out_used_nxt  = used_nxt;
          out_free_nxt  = free_nxt;
        end
      end
      default: ;
    endcase

    // new total: counts restart and the map is swept clean
    if (cfg_we) begin
      total_cells_nxt = cfg_wdata;
      used_nxt        = '0;
      free_nxt        = eff_of(cfg_wdata);
      clr_addr_nxt    = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      total_cells_r <= TOTAL_RST;
      used_r        <= '0;
      free_r        <= eff_of(TOTAL_RST);
      clr_addr_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      total_cells_r <= total_cells_nxt;
      used_r        <= used_nxt;
      free_r        <= free_nxt;
      clr_addr_r    <= clr_addr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    size_r     <= size_nxt;
    base_r     <= base_nxt;
    last_r     <= last_nxt;
    word_r     <= word_nxt;
    run_r      <= run_nxt;
    ok_r       <= ok_nxt;
    out_ok_r   <= out_ok_nxt;
    out_base_r <= out_base_nxt;
    out_used_r <= out_used_nxt;
    out_free_r <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {out_free_r, out_used_r, out_base_r};

  // occupied and free counts together never exceed the cells in use
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, used_r} + {1'b0, free_r}) <= {1'b0, eff_total})
    else $error("used and free counts exceed total cells");

  // a run being marked lies inside the cells in use
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (base_r <= last_r) && (last_r < eff_total))
    else $error("marked run outside the map");

  // a granted run spans exactly the requested size
  a_grant_size: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && ok_r && kind_r == KIND_ALLOC) |->
      (CELL_W'(last_r - base_r + CELL_W'(1)) == size_r))
    else $error("granted run length differs from request");

  // the map is written only while sweeping or marking
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR) || (state_r == ST_MARK))
    else $error("map written outside sweep or mark");

endmodule

@@ rtl/core/ffca_ram.sv @@
// generic simple dual-port ram with registered read
// no package dependency

module ffca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ffca_word_scan.sv @@
// free-run search across one word of the occupancy map
// depends on ffca_pkg

module ffca_word_scan (
  input  logic [ffca_pkg::LANES-1:0]  occ,
  input  logic [ffca_pkg::WIDX_W-1:0] word,
  input  logic [ffca_pkg::CELL_W-1:0] run_in,
  input  logic [ffca_pkg::CELL_W-1:0] size,
  input  logic [ffca_pkg::CELL_W-1:0] total,
  output ffca_pkg::scan_res_t         res
);
  import ffca_pkg::*;

  logic [RUN_W-1:0] run_lane [LANES];
  logic [LANES-1:0] hit_lane;

  // run length ending at each lane: from the last used cell at or below it,
  // or carried in from the previous word when the word is free up to there
  always_comb begin
    logic              seen;
    logic [LANE_W-1:0] last;
    logic [CELL_W-1:0] cell_idx;
    for (int i = 0; i < LANES; i++) begin
      seen = 1'b0;
      last = '0;
      for (int j = 0; j <= i; j++) begin
        if (occ[j]) begin
          seen = 1'b1;
          last = LANE_W'(j);
        end
      end
      cell_idx = {word, LANE_W'(i)};
      if (seen) begin
        run_lane[i] = RUN_W'(i) - RUN_W'(last);
      end else begin
        run_lane[i] = {1'b0, run_in} + RUN_W'(i + 1);
      end
      hit_lane[i] = (run_lane[i] >= {1'b0, size}) && (cell_idx < total);
    end
  end

  always_comb begin
    logic [LANE_W-1:0] pos;
    pos = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (hit_lane[i]) begin
        pos = LANE_W'(i);
      end
    end
    res.hit      = |hit_lane;
    res.end_cell = {word, pos};
    res.run      = run_lane[LANES-1][CELL_W-1:0];
  end

endmodule

@@ sim/first_fit_cell_allocator_check.sv @@
`timescale 1ns / 1ps
// scoreboard for the first-fit cell allocator: mirrors the occupancy map and
// counts, predicts one grant per request transfer and compares each result
// depends on ffca_pkg for widths, request kinds and the reset total

module first_fit_cell_allocator_check #(
  parameter int CELLS = ffca_pkg::CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [10:0] size, [20:11] base, zero padding
  input  logic        in_tuser,   // kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [9:0] granted_base, [20:10] used, [31:21] free
  input  logic        out_tuser,  // ok
  output int          mismatches,
  output int          outstanding
);
  import ffca_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] granted_base;
    logic [CELL_W-1:0] used_cells;
    logic [CELL_W-1:0] free_cells;
  } grant_t;

  logic [CELLS-1:0]  occupied;
  int unsigned       used_n;
  int unsigned       free_n;
  logic [CELL_W-1:0] total_reg;
  grant_t            grant_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int unsigned usable_cells();
    return (total_reg < CELLS) ? total_reg : CELLS;
  endfunction

  function automatic void restart_map();
    occupied = '0;
    used_n   = 0;
    free_n   = usable_cells();
  endfunction

  // applies one request to the mirrored map and returns the grant it yields
  function automatic grant_t serve_request(input logic [KIND_W-1:0] kind,
                                           input int unsigned size,
                                           input int unsigned base);
    grant_t      r;
    int unsigned lim, run, at, i;
    bit          hit;
    lim = usable_cells();
    r   = '0;
    hit = 1'b0;
    at  = 0;
    run = 0;
    if (kind == KIND_ALLOC) begin
      if (size != 0 && size <= lim) begin
        for (i = 0; i < lim && !hit; i++) begin
          run = occupied[i] ? 0 : run + 1;
          if (run == size) begin
            hit = 1'b1;
            at  = i + 1 - size;
          end
        end
        if (hit) begin
          for (i = at; i < at + size; i++) occupied[i] = 1'b1;
          free_n = (free_n > size) ? free_n - size : 0;
          used_n = (used_n + size > lim) ? lim : used_n + size;
        end
      end
    end else if (size != 0 && base + size <= lim) begin
      // freeing never-used cells still moves both counts, saturating
      for (i = base; i < base + size; i++) occupied[i] = 1'b0;
      used_n = (used_n > size) ? used_n - size : 0;
      free_n = (free_n + size > lim) ? lim : free_n + size;
      hit    = 1'b1;
    end
    r.ok           = hit;
    r.granted_base = hit ? BASE_W'(at) : '0;
    r.used_cells   = CELL_W'(used_n);
    r.free_cells   = CELL_W'(free_n);
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    grant_t seen, want;
    if (!rst_n) begin
      total_reg = TOTAL_RST;
      restart_map();
      grant_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tuser, out_tdata[9:0], out_tdata[20:10], out_tdata[31:21]};
        if (grant_q.size() == 0) begin
          flag_mismatch($sformatf("result transfer with nothing expected: %h", seen));
        end else begin
          want = grant_q.pop_front();
          if (seen.ok !== want.ok)
            flag_mismatch($sformatf("ok %b, expected %b", seen.ok, want.ok));
          if (seen.granted_base !== want.granted_base)
            flag_mismatch($sformatf("granted_base %0d, expected %0d",
                                    seen.granted_base, want.granted_base));
          if (seen.used_cells !== want.used_cells)
            flag_mismatch($sformatf("used_cells %0d, expected %0d",
                                    seen.used_cells, want.used_cells));
          if (seen.free_cells !== want.free_cells)
            flag_mismatch($sformatf("free_cells %0d, expected %0d",
                                    seen.free_cells, want.free_cells));
        end
      end
      // a total write clears the map and restarts both counts
      if (cfg_we) begin
        total_reg = cfg_wdata;
        restart_map();
      end
      if (in_tvalid && in_tready)
        grant_q.insert(grant_q.size(),
                       serve_request(in_tuser, 32'(in_tdata[10:0]), 32'(in_tdata[20:11])));
    end
    outstanding = grant_q.size();
  end

endmodule

@@ sim/first_fit_cell_allocator_test.sv @@
`timescale 1ns / 1ps
// top of the first-fit cell allocator testbench: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict
// depends on ffca_pkg, first_fit_cell_allocator and first_fit_cell_allocator_check

module first_fit_cell_allocator_test;
  import ffca_pkg::*;

  localparam int CELLS       = CELLS_DEF;
  // cycles with no transfer on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [10:0] size, [20:11] base, zero padding
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [9:0] granted_base, [20:10] used_cells, [31:21] free_cells
  logic        out_tuser;  // ok

  int          mismatches;
  int          outstanding;
  int          quiet;
  int unsigned idle_pct;     // chance per cycle that the sender holds off
  int unsigned stall_pct;    // chance per cycle that the receiver stalls
  int unsigned cur_total;    // last value written to total_cells

  first_fit_cell_allocator #(.CELLS(CELLS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  first_fit_cell_allocator_check #(.CELLS(CELLS)) grant_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any transfer on either channel resets the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [CELL_W-1:0] size,
                              input logic [BASE_W-1:0] base);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, base, size};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop sending and hold until every outstanding result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // only written with the block idle
  task automatic set_total(input int unsigned value, input int unsigned idle,
                           input int unsigned stall);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= 11'(value);
    cur_total  = value;
    idle_pct   = idle;
    stall_pct  = stall;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed allocate and free traffic sized to the current total,
  // with a share of rejects and fully random noise
  task automatic random_request();
    int unsigned lim, roll, sz, top_sz;
    lim    = (cur_total < CELLS) ? cur_total : CELLS;
    roll   = $urandom_range(99);
    top_sz = (lim / 8 > 1) ? lim / 8 : 1;
    if (lim == 0 || roll >= 95) begin
      send_request(KIND_W'($urandom_range(1)), CELL_W'($urandom_range(2047)),
                   BASE_W'($urandom_range(1023)));
    end else if (roll < 50) begin
      sz = ($urandom_range(99) < 85) ? $urandom_range(top_sz, 1) : $urandom_range(lim, 1);
      send_request(KIND_ALLOC, CELL_W'(sz), BASE_W'($urandom_range(1023)));
    end else if (roll < 85) begin
      sz = $urandom_range(top_sz, 1);
      send_request(KIND_FREE, CELL_W'(sz), BASE_W'($urandom_range(lim - sz, 0)));
    end else if (roll < 90) begin
      send_request(KIND_FREE, CELL_W'(lim), '0);
    end else begin
      // free run that overhangs the end by one cell
      sz = $urandom_range(top_sz + 1, 2);
      send_request(KIND_FREE, CELL_W'(sz), BASE_W'(lim - sz + 1));
    end
  endtask

  // pause_at > 0 makes the sender wait for every result part way through
  task automatic random_burst(input int n, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (pause_at != 0 && i == pause_at) drain();
      random_request();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_ALLOC;
    out_tready = 1'b0;
    quiet      = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    cur_total  = TOTAL_RST;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: full map, rejects, boundary frees, holes
    set_total(1024, 0, 0);
    send_request(KIND_ALLOC, 11'd0,    10'd0);     // zero size
    send_request(KIND_ALLOC, 11'd2047, 10'd0);     // beyond the cell count
    send_request(KIND_ALLOC, 11'd1025, 10'd0);
    send_request(KIND_ALLOC, 11'd1024, 10'd1023);  // whole map, base ignored
    send_request(KIND_ALLOC, 11'd1,    10'd0);     // no fit
    send_request(KIND_FREE,  11'd1,    10'd1023);  // last cell
    send_request(KIND_FREE,  11'd2,    10'd1023);  // past the end
    send_request(KIND_ALLOC, 11'd1,    10'd0);     // lands on the last cell
    send_request(KIND_FREE,  11'd1024, 10'd0);
    send_request(KIND_FREE,  11'd1024, 10'd0);     // never used, counts saturate
    send_request(KIND_ALLOC, 11'd3,    10'd0);
    send_request(KIND_ALLOC, 11'd5,    10'd0);
    send_request(KIND_FREE,  11'd1,    10'd1);     // one-cell hole
    send_request(KIND_ALLOC, 11'd2,    10'd0);     // skips the hole
    send_request(KIND_ALLOC, 11'd1,    10'd0);     // fills the hole
    send_request(KIND_FREE,  11'd0,    10'd5);     // zero size free
    send_request(KIND_FREE,  11'd512,  10'd512);
    send_request(KIND_ALLOC, 11'd1024, 10'd0);
    send_request(KIND_FREE,  11'd1024, 10'd0);
    random_burst(200, 0);

    // no cells: everything rejected
    set_total(0, 16, 16);
    random_burst(20, 0);
    // above CELLS: clipped to the full map
    set_total(2047, 77, 0);
    random_burst(200, 0);
    set_total(1, 0, 77);
    random_burst(60, 0);
    set_total(100, 16, 16);
    random_burst(250, 125);
    set_total(37, 0, 0);
    random_burst(150, 0);
    set_total(512, 0, 77);
    random_burst(100, 0);

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
